FILE: src/gcm_pkg.sv
// Package: constants, S-box tables and round function for the counter-mode cipher.
`default_nettype none
package gcm_pkg;

    localparam int unsigned DATA_W     = 64;
    localparam int unsigned HALF_W     = 32;
    localparam int unsigned ROUNDS     = 32;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned SBOX_SET_DEFAULT = 0;
    localparam int unsigned FIFO_DEPTH = 2;

    localparam logic [HALF_W-1:0] CTR_ADD_HIGH = 32'h0101_0104;
    localparam logic [HALF_W-1:0] CTR_ADD_LOW  = 32'h0101_0101;
    localparam int unsigned ROT_LEFT  = 11;
    localparam int unsigned ROT_RIGHT = 21;

    // Register indexes on the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KEY_0_1 = 3'd0,
        REG_KEY_2_3 = 3'd1,
        REG_KEY_4_5 = 3'd2,
        REG_KEY_6_7 = 3'd3,
        REG_IV      = 3'd4
    } cfg_reg_t;

    typedef logic [HALF_W-1:0] word32_t;
    typedef word32_t key_sched_t [8];

    // Item handed from front to back: counter value and data word
    typedef struct packed {
        logic [DATA_W-1:0] ctr;
        logic [DATA_W-1:0] data;
    } work_item_t;

    typedef logic [3:0] sbox_row_t [16];
    typedef sbox_row_t sbox_set_t [8];

    localparam sbox_set_t SBOX_Z = '{
        '{4'd12, 4'd4, 4'd6, 4'd2, 4'd10, 4'd5, 4'd11, 4'd9,
          4'd14, 4'd8, 4'd13, 4'd7, 4'd0, 4'd3, 4'd15, 4'd1},
        '{4'd6, 4'd8, 4'd2, 4'd3, 4'd9, 4'd10, 4'd5, 4'd12,
          4'd1, 4'd14, 4'd4, 4'd7, 4'd11, 4'd13, 4'd0, 4'd15},
        '{4'd11, 4'd3, 4'd5, 4'd8, 4'd2, 4'd15, 4'd10, 4'd13,
          4'd14, 4'd1, 4'd7, 4'd4, 4'd12, 4'd9, 4'd6, 4'd0},
        '{4'd12, 4'd8, 4'd2, 4'd1, 4'd13, 4'd4, 4'd15, 4'd6,
          4'd7, 4'd0, 4'd10, 4'd5, 4'd3, 4'd14, 4'd9, 4'd11},
        '{4'd7, 4'd15, 4'd5, 4'd10, 4'd8, 4'd1, 4'd6, 4'd13,
          4'd0, 4'd9, 4'd3, 4'd14, 4'd11, 4'd4, 4'd2, 4'd12},
        '{4'd5, 4'd13, 4'd15, 4'd6, 4'd9, 4'd2, 4'd12, 4'd10,
          4'd11, 4'd7, 4'd8, 4'd1, 4'd4, 4'd3, 4'd14, 4'd0},
        '{4'd8, 4'd14, 4'd2, 4'd5, 4'd6, 4'd9, 4'd1, 4'd12,
          4'd15, 4'd4, 4'd11, 4'd0, 4'd13, 4'd10, 4'd3, 4'd7},
        '{4'd1, 4'd7, 4'd14, 4'd13, 4'd0, 4'd5, 4'd8, 4'd3,
          4'd4, 4'd15, 4'd10, 4'd6, 4'd9, 4'd12, 4'd11, 4'd2}
    };

    localparam sbox_set_t SBOX_TEST = '{
        '{4'd4, 4'd10, 4'd9, 4'd2, 4'd13, 4'd8, 4'd0, 4'd14,
          4'd6, 4'd11, 4'd1, 4'd12, 4'd7, 4'd15, 4'd5, 4'd3},
        '{4'd14, 4'd11, 4'd4, 4'd12, 4'd6, 4'd13, 4'd15, 4'd10,
          4'd2, 4'd3, 4'd8, 4'd1, 4'd0, 4'd7, 4'd5, 4'd9},
        '{4'd5, 4'd8, 4'd1, 4'd13, 4'd10, 4'd3, 4'd4, 4'd2,
          4'd14, 4'd15, 4'd12, 4'd7, 4'd6, 4'd0, 4'd9, 4'd11},
        '{4'd7, 4'd13, 4'd10, 4'd1, 4'd0, 4'd8, 4'd9, 4'd15,
          4'd14, 4'd4, 4'd6, 4'd12, 4'd11, 4'd2, 4'd5, 4'd3},
        '{4'd6, 4'd12, 4'd7, 4'd1, 4'd5, 4'd15, 4'd13, 4'd8,
          4'd4, 4'd10, 4'd9, 4'd14, 4'd0, 4'd3, 4'd11, 4'd2},
        '{4'd4, 4'd11, 4'd10, 4'd0, 4'd7, 4'd2, 4'd1, 4'd13,
          4'd3, 4'd6, 4'd8, 4'd5, 4'd9, 4'd12, 4'd15, 4'd14},
        '{4'd13, 4'd11, 4'd4, 4'd1, 4'd3, 4'd15, 4'd5, 4'd9,
          4'd0, 4'd10, 4'd14, 4'd7, 4'd6, 4'd8, 4'd2, 4'd12},
        '{4'd1, 4'd15, 4'd13, 4'd0, 4'd5, 4'd7, 4'd10, 4'd4,
          4'd9, 4'd2, 4'd3, 4'd14, 4'd6, 4'd11, 4'd8, 4'd12}
    };

    // Round function: add key, substitute nibbles, rotate left by 11
    function automatic word32_t round_fn(input word32_t x, input word32_t k,
                                         input logic set_sel);
        word32_t s;
        word32_t y;
        s = x + k;
        y = '0;
        for (int p = 0; p < 8; p++)
        begin
            y[4*p +: 4] = set_sel ? SBOX_TEST[p][s[4*p +: 4]] : SBOX_Z[p][s[4*p +: 4]];
        end
        return (y << ROT_LEFT) | (y >> ROT_RIGHT);
    endfunction

    // Key word used in round r
    function automatic logic [2:0] key_index(input int unsigned r);
        logic [2:0] low3;
        low3 = 3'(r);
        return (r < 24) ? low3 : (3'd7 - low3);
    endfunction

    // Counter advance: high half mod 2^32-1, low half mod 2^32
    function automatic logic [DATA_W-1:0] ctr_advance(input logic [DATA_W-1:0] c);
        logic [HALF_W:0]   hs;
        logic [HALF_W-1:0] hi;
        logic [HALF_W-1:0] lo;
        hs = {1'b0, c[DATA_W-1:HALF_W]} + {1'b0, CTR_ADD_HIGH};
        hi = hs[HALF_W-1:0] + {{(HALF_W-1){1'b0}}, hs[HALF_W]};
        lo = c[HALF_W-1:0] + CTR_ADD_LOW;
        return {hi, lo};
    endfunction

endpackage
`default_nettype wire

FILE: src/gcm_if.sv
// Interfaces: valid/ready stream channel and configuration write channel.
`default_nettype none
interface gcm_stream_if
    import gcm_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] data_block;
    logic [DATA_W-1:0] result_block;
    modport source (output valid, output data_block, output result_block, input ready);
    modport sink   (input valid, input data_block, input result_block, output ready);
endinterface

interface gcm_cfg_if
    import gcm_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [DATA_W-1:0]    wdata;
    modport source (output valid, output index, output wdata, input ready);
    modport sink   (input valid, input index, input wdata, output ready);
endinterface
`default_nettype wire

FILE: src/gcm_front.sv
// Front end: accepts data words, advances the counter, pushes work into the queue.
`default_nettype none
module gcm_front
    import gcm_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [DATA_W-1:0] in_data,
    input  wire logic              iv_load,
    input  wire logic [DATA_W-1:0] iv_value,
    output logic                   push,
    output work_item_t             push_item,
    input  wire logic              q_full
);
    logic [DATA_W-1:0] ctr_reg;
    logic [DATA_W-1:0] ctr_next;

    assign in_ready  = !q_full;
    assign push      = in_valid && in_ready;
    assign ctr_next  = ctr_advance(ctr_reg);
    assign push_item = '{ctr: ctr_next, data: in_data};

    // Keystream counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctr_reg <= '0;
        else if (iv_load)
            ctr_reg <= iv_value;
        else if (push)
            ctr_reg <= ctr_next;
    end
endmodule
`default_nettype wire

FILE: src/gcm_queue.sv
// Short FIFO between front and back ends.
`default_nettype none
module gcm_queue
    import gcm_pkg::*;
#(
    parameter int unsigned DEPTH = FIFO_DEPTH
)(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  work_item_t      push_item,
    output logic            full,
    input  wire logic       pop,
    output logic            not_empty,
    output work_item_t      pop_item
);
    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    work_item_t           mem [DEPTH];
    logic [PTR_W-1:0]     wp_reg;
    logic [PTR_W-1:0]     rp_reg;
    logic [PTR_W:0]       cnt_reg;

    assign full      = (cnt_reg == (PTR_W+1)'(DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign pop_item  = mem[rp_reg];

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wp_reg] <= push_item;
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= (wp_reg == PTR_W'(DEPTH-1)) ? '0 : wp_reg + 1'b1;
            if (pop)
                rp_reg <= (rp_reg == PTR_W'(DEPTH-1)) ? '0 : rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) full |-> !push)
        else $error("queue push while full");
    assert property (@(posedge clk) disable iff (!rst_n) !not_empty |-> !pop)
        else $error("queue pop while empty");
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (PTR_W+1)'(DEPTH))
        else $error("queue count overflow");
endmodule
`default_nettype wire

FILE: src/gcm_back.sv
// Back end: input register, then 32-stage Feistel pipeline, one round per stage, then XOR with data.
`default_nettype none
module gcm_back
    import gcm_pkg::*;
#(
    parameter int unsigned SBOX_SET = SBOX_SET_DEFAULT
)(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  work_item_t             in_item,
    input  key_sched_t             keys,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [DATA_W-1:0]      out_data
);
    localparam logic SET_SEL = SBOX_SET[0];

    logic [ROUNDS:0]   vld_reg;
    word32_t           n1_reg  [ROUNDS+1];
    word32_t           n2_reg  [ROUNDS+1];
    logic [DATA_W-1:0] dat_reg [ROUNDS+1];
    logic              adv;

    // Pipeline moves when the last stage is empty or being taken
    assign adv       = !vld_reg[ROUNDS] || out_ready;
    assign in_ready  = adv;
    assign out_valid = vld_reg[ROUNDS];
    assign out_data  = dat_reg[ROUNDS] ^ {n2_reg[ROUNDS], n1_reg[ROUNDS]};

    // Stage 0 loads the advanced counter
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            n1_reg[0]  <= in_item.ctr[HALF_W-1:0];
            n2_reg[0]  <= in_item.ctr[DATA_W-1:HALF_W];
            dat_reg[0] <= in_item.data;
        end
    end

    // Round stages
    for (genvar r = 0; r < ROUNDS; r++)
    begin : g_round
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dat_reg[r+1] <= dat_reg[r];
                if ((r % 2) == 0)
                begin
                    n1_reg[r+1] <= n1_reg[r];
                    n2_reg[r+1] <= n2_reg[r] ^ round_fn(n1_reg[r], keys[key_index(r)], SET_SEL);
                end
                else
                begin
                    n2_reg[r+1] <= n2_reg[r];
                    n1_reg[r+1] <= n1_reg[r] ^ round_fn(n2_reg[r], keys[key_index(r)], SET_SEL);
                end
            end
        end
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[ROUNDS-1:0], in_valid};
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
        else $error("result changed while stalled");
    assert property (@(posedge clk) disable iff (!rst_n)
        (!adv) |=> $stable(vld_reg))
        else $error("pipeline moved while stalled");
    assert property (@(posedge clk) disable iff (!rst_n)
        (adv && in_valid) |=> vld_reg[0])
        else $error("accepted item lost at pipeline entry");
endmodule
`default_nettype wire

FILE: src/gost_counter_mode_cipher_top.sv
// Top level: configuration registers, front end, queue and cipher pipeline.
// One 64-bit data word is taken per cycle while the output is not stalled; on its way
// it passes the queue, the stage-0 register and 32 round stages (the final XOR is combinational); the
// sustained rate is one word per clock, set by the fully pipelined 32-round Feistel core. The
// counter is advanced in the front end at acceptance, so a stalled output only stops
// intake once the two-entry queue is full. Writing REG_IV reloads the counter.
`default_nettype none
module gost_counter_mode_cipher_top
    import gcm_pkg::*;
#(
    parameter int unsigned SBOX_SET = SBOX_SET_DEFAULT
)(
    input  wire logic    clk,
    input  wire logic    rst_n,
    gcm_stream_if.sink   data_in,
    gcm_stream_if.source data_out,
    gcm_cfg_if.sink      cfg
);
    key_sched_t  key_reg;
    logic        cfg_wr;
    logic        iv_load;
    logic        push;
    logic        q_full;
    logic        q_ne;
    logic        pop;
    logic        back_ready;
    work_item_t  push_item;
    work_item_t  pop_item;

    assign cfg.ready = 1'b1;
    assign cfg_wr    = cfg.valid;
    assign iv_load   = cfg_wr && (cfg.index == REG_IV);

    // Key registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
                key_reg[i] <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg.index)
                REG_KEY_0_1: begin key_reg[0] <= cfg.wdata[31:0]; key_reg[1] <= cfg.wdata[63:32]; end
                REG_KEY_2_3: begin key_reg[2] <= cfg.wdata[31:0]; key_reg[3] <= cfg.wdata[63:32]; end
                REG_KEY_4_5: begin key_reg[4] <= cfg.wdata[31:0]; key_reg[5] <= cfg.wdata[63:32]; end
                REG_KEY_6_7: begin key_reg[6] <= cfg.wdata[31:0]; key_reg[7] <= cfg.wdata[63:32]; end
                default: ;
            endcase
        end
    end

    gcm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (data_in.valid),
        .in_ready  (data_in.ready),
        .in_data   (data_in.data_block),
        .iv_load   (iv_load),
        .iv_value  (cfg.wdata),
        .push      (push),
        .push_item (push_item),
        .q_full    (q_full)
    );

    gcm_queue #(.DEPTH(FIFO_DEPTH)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .not_empty (q_ne),
        .pop_item  (pop_item)
    );

    assign pop = q_ne && back_ready;

    gcm_back #(.SBOX_SET(SBOX_SET)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (q_ne),
        .in_ready  (back_ready),
        .in_item   (pop_item),
        .keys      (key_reg),
        .out_valid (data_out.valid),
        .out_ready (data_out.ready),
        .out_data  (data_out.result_block)
    );

    assign data_out.data_block = '0;
endmodule
`default_nettype wire
